/* design/bad_pkg.sv */
// Package for the banked address decoder: store geometry, command, size and
// target codes, bank constants and the decode / lane helper functions.
// No dependencies.
package bad_pkg;

    localparam int CHIP_ADDR_BITS = 21;                 // chip RAM byte address bits
    localparam int ROM_ADDR_BITS  = 19;                 // ROM byte address bits
    localparam int CHIP_ROW_W     = CHIP_ADDR_BITS - 2; // one row is one long word
    localparam int ROM_ROW_W      = ROM_ADDR_BITS - 2;
    localparam int CHIP_ROWS      = 1 << CHIP_ROW_W;
    localparam int ROM_ROWS       = 1 << ROM_ROW_W;

    localparam logic [4:0] CHIP_LOG2_MIN   = 5'd16;
    localparam logic [4:0] CHIP_LOG2_MAX   = 5'(CHIP_ADDR_BITS);
    localparam logic [4:0] CHIP_LOG2_RESET = 5'd19;
    localparam logic [4:0] CHIP_LOG2_BASE  = 5'd21;     // above this, chip owns more banks

    localparam logic [7:0] BANK_CIA_LO    = 8'hA0;
    localparam logic [7:0] BANK_CUSTOM_LO = 8'hC0;
    localparam logic [7:0] BANK_CLOCK     = 8'hDC;
    localparam logic [7:0] BANK_CUSTOM_HI = 8'hE0;
    localparam logic [7:0] BANK_ROM_LO    = 8'hF8;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [0:0] CFG_CHIP_SIZE  = 1'b0;
    localparam logic [0:0] CFG_ROM_MIRROR = 1'b1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_WORD = 2'd1,
        SZ_LONG = 2'd2
    } t_size;

    typedef enum logic [2:0] {
        TGT_CHIP   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_CIA    = 3'd2,
        TGT_CUSTOM = 3'd3,
        TGT_CLOCK  = 3'd4,
        TGT_NONE   = 3'd5
    } t_target;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic [CHIP_ROW_W-1:0] row;
        logic [31:0]           wdata;
    } t_chip_req;

    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [ROM_ROW_W-1:0] row;
        logic [31:0]          wdata;
    } t_rom_req;

    // all ones of the access size
    function automatic logic [31:0] size_fill(t_size sz);
        logic [31:0] f;
        unique case (sz)
            SZ_BYTE: f = 32'h0000_00FF;
            SZ_WORD: f = 32'h0000_FFFF;
            default: f = ALL_ONES;
        endcase
        return f;
    endfunction

    // low lg bits set
    function automatic logic [CHIP_ADDR_BITS-1:0] chip_mask(logic [4:0] lg);
        logic [CHIP_ADDR_BITS-1:0] m;
        for (int i = 0; i < CHIP_ADDR_BITS; i++) begin
            m[i] = (5'(i) < lg);
        end
        return m;
    endfunction

    function automatic t_target decode(logic [15:0] bank, logic [4:0] lg);
        t_target     t;
        logic        is_chip;
        logic [15:0] hi;
        hi      = bank >> (lg - CHIP_LOG2_MIN);
        is_chip = (bank[15:5] == 11'd0) || ((lg > CHIP_LOG2_BASE) && (hi == 16'd0));
        if (is_chip) begin
            t = TGT_CHIP;
        end else if (bank[15:8] != 8'd0) begin
            t = TGT_NONE;
        end else if (bank[7:0] >= BANK_CIA_LO && bank[7:0] < BANK_CUSTOM_LO) begin
            t = TGT_CIA;
        end else if (bank[7:0] == BANK_CLOCK) begin
            t = TGT_CLOCK;
        end else if (bank[7:0] >= BANK_CUSTOM_LO && bank[7:0] < BANK_CUSTOM_HI) begin
            t = TGT_CUSTOM;
        end else if (bank[7:0] >= BANK_ROM_LO) begin
            t = TGT_ROM;
        end else begin
            t = TGT_NONE;
        end
        return t;
    endfunction

    // big-endian lane pick from a long-word row; byte 0 sits in bits 31:24
    function automatic logic [31:0] lane_read(logic [31:0] row, t_size sz, logic [1:0] sel);
        logic [31:0] sh;
        logic [31:0] v;
        sh = row << {sel, 3'b000};
        unique case (sz)
            SZ_BYTE: v = {24'd0, sh[31:24]};
            SZ_WORD: v = sel[1] ? {16'd0, row[15:0]} : {16'd0, row[31:16]};
            default: v = row;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] lane_merge(logic [31:0] row, t_size sz, logic [1:0] sel,
                                               logic [31:0] d);
        logic [31:0] m;
        logic [31:0] b;
        logic [31:0] v;
        m = 32'hFF00_0000 >> {sel, 3'b000};
        b = {d[7:0], 24'd0} >> {sel, 3'b000};
        unique case (sz)
            SZ_BYTE: v = (row & ~m) | b;
            SZ_WORD: v = sel[1] ? {row[31:16], d[15:0]} : {d[15:0], row[15:0]};
            default: v = d;
        endcase
        return v;
    endfunction

endpackage

/* design/bad_chip_mem.sv */
// Chip RAM: long-word rows, registered read, zeroing sweep after reset.
// Depends on bad_pkg.
module bad_chip_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bad_pkg::t_chip_req i_req,
    output logic [31:0]        o_rd_data,
    output logic               o_clearing
);
    import bad_pkg::*;

    logic [31:0]           r_mem [CHIP_ROWS];
    logic [31:0]           r_rd_data;
    logic [CHIP_ROW_W-1:0] r_clr_row;
    logic                  r_clearing;
    logic                  w_we;
    logic [CHIP_ROW_W-1:0] w_waddr;
    logic [31:0]           w_wdata;

    assign w_we    = r_clearing || i_req.wr;
    assign w_waddr = r_clearing ? r_clr_row : i_req.row;
    assign w_wdata = r_clearing ? 32'd0 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == CHIP_ROW_W'(CHIP_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_req.row];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

/* design/bad_rom_mem.sv */
// ROM store in long-word rows with registered read, plus the running
// end-around-carry checksum kept over ROM loads. Depends on bad_pkg.
module bad_rom_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bad_pkg::t_rom_req i_req,
    output logic [31:0]       o_rd_data,
    output logic              o_cs_ok_next
);
    import bad_pkg::*;

    logic [31:0] r_mem [ROM_ROWS];
    logic [31:0] r_rd_data;
    logic [31:0] r_checksum;
    logic [31:0] n_checksum;
    logic [32:0] w_sum;

    assign w_sum      = {1'b0, r_checksum} + {1'b0, i_req.wdata};
    assign n_checksum = w_sum[31:0] + {31'd0, w_sum[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum <= '0;
        end else if (i_req.wr) begin
            r_checksum <= n_checksum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.row] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_req.row];
        end
    end

    assign o_rd_data    = r_rd_data;
    // status after this cycle's load, if any
    assign o_cs_ok_next = (i_req.wr ? n_checksum : r_checksum) == ALL_ONES;

endmodule

/* design/banked_address_decoder_ram_rom_top.sv */
// Banked address decoder top: bank decode, read-modify-write control and result
// register over chip RAM and ROM stores. Depends on bad_pkg, bad_chip_mem, bad_rom_mem.
//
//   channel   handshake                   payload
//   input     i_in_valid / o_in_stall     i_command i_access_size i_address i_write_data
//   output    o_out_valid / i_out_stall   o_read_data o_target o_checksum_ok
//   config    i_cfg_we                    i_cfg_index i_cfg_wdata
//
// Each transaction: the accept edge launches the store read, the edge that leaves S_EXEC
// writes the modified row back and loads the result register (one store port).
// After reset the chip RAM is zeroed one row per cycle, all 2^19 = 524288 rows, with
// o_in_stall high; configuration writes are taken throughout.
// A stalled result holds the transaction in S_EXEC; a new transaction is still taken while
// the result register waits.
module banked_address_decoder_ram_rom_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_target,
    output logic        o_checksum_ok
);
    import bad_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [4:0]            r_chip_log2;
    logic                  r_rom_mirror;
    t_cmd                  r_cmd;
    t_size                 r_size;
    logic [1:0]            r_sel;
    logic [31:0]           r_wdata;
    t_target               r_tgt;
    logic [CHIP_ROW_W-1:0] r_chip_row;
    logic [ROM_ROW_W-1:0]  r_rom_row;
    logic                  r_out_valid;
    logic [31:0]           r_rdata;
    t_target               r_out_tgt;
    logic                  r_cs_ok;

    logic                      w_accept;
    logic                      w_fire;
    t_cmd                      w_cmd;
    t_size                     w_size;
    logic [31:0]               w_addr;
    logic [4:0]                w_eff_lg;
    logic [CHIP_ADDR_BITS-1:0] w_chip_off;
    logic [ROM_ADDR_BITS-1:0]  w_rom_off;
    t_target                   w_tgt;
    logic [31:0]               w_wdata;
    logic [31:0]               w_rdata;
    logic [31:0]               w_chip_rd;
    logic [31:0]               w_rom_rd;
    logic                      w_clearing;
    logic                      w_cs_ok_next;
    t_chip_req                 w_chip_req;
    t_rom_req                  w_rom_req;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_fire   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // ---- decode of the incoming transaction ----
    assign w_cmd  = t_cmd'(i_command);
    assign w_size = i_access_size[1] ? SZ_LONG : (i_access_size[0] ? SZ_WORD : SZ_BYTE);

    always_comb begin
        unique case (w_size)
            SZ_WORD: w_addr = {i_address[31:1], 1'b0};
            SZ_LONG: w_addr = {i_address[31:2], 2'b00};
            default: w_addr = i_address;
        endcase
    end

    always_comb begin
        priority if (r_chip_log2 < CHIP_LOG2_MIN) begin
            w_eff_lg = CHIP_LOG2_MIN;
        end else if (r_chip_log2 > CHIP_LOG2_MAX) begin
            w_eff_lg = CHIP_LOG2_MAX;
        end else begin
            w_eff_lg = r_chip_log2;
        end
    end

    assign w_chip_off = w_addr[CHIP_ADDR_BITS-1:0] & chip_mask(w_eff_lg);

    always_comb begin
        w_rom_off = w_addr[ROM_ADDR_BITS-1:0];
        // half-size image: upper half reads the lower half
        if (w_cmd != CMD_LOAD && r_rom_mirror) begin
            w_rom_off[ROM_ADDR_BITS-1] = 1'b0;
        end
    end

    assign w_tgt   = (w_cmd == CMD_LOAD) ? TGT_ROM : decode(w_addr[31:16], w_eff_lg);
    assign w_wdata = (w_cmd == CMD_LOAD) ? i_write_data : (i_write_data & size_fill(w_size));

    // ---- store requests ----
    always_comb begin
        w_chip_req.rd    = w_accept;
        w_chip_req.wr    = w_fire && (r_cmd == CMD_WRITE) && (r_tgt == TGT_CHIP);
        w_chip_req.row   = w_accept ? w_chip_off[CHIP_ADDR_BITS-1:2] : r_chip_row;
        w_chip_req.wdata = lane_merge(w_chip_rd, r_size, r_sel, r_wdata);

        w_rom_req.rd    = w_accept;
        w_rom_req.wr    = w_fire && (r_cmd == CMD_LOAD);
        w_rom_req.row   = w_accept ? w_rom_off[ROM_ADDR_BITS-1:2] : r_rom_row;
        w_rom_req.wdata = r_wdata;
    end

    bad_chip_mem u_chip (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_chip_req),
        .o_rd_data  (w_chip_rd),
        .o_clearing (w_clearing)
    );

    bad_rom_mem u_rom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_rom_req),
        .o_rd_data    (w_rom_rd),
        .o_cs_ok_next (w_cs_ok_next)
    );

    always_comb begin
        w_rdata = 32'd0;
        if (r_cmd == CMD_READ) begin
            unique case (r_tgt)
                TGT_CHIP: w_rdata = lane_read(w_chip_rd, r_size, r_sel);
                TGT_ROM:  w_rdata = lane_read(w_rom_rd, r_size, r_sel);
                TGT_NONE: w_rdata = size_fill(r_size);
                default:  w_rdata = 32'd0;
            endcase
        end
    end

    // ---- control ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (!w_clearing) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid)  n_state = S_EXEC;
            S_EXEC:  if (w_fire)      n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_chip_log2  <= CHIP_LOG2_RESET;
            r_rom_mirror <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHIP_SIZE:  r_chip_log2  <= i_cfg_wdata;
                    CFG_ROM_MIRROR: r_rom_mirror <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= w_cmd;
            r_size     <= w_size;
            r_sel      <= w_addr[1:0];
            r_wdata    <= w_wdata;
            r_tgt      <= w_tgt;
            r_chip_row <= w_chip_off[CHIP_ADDR_BITS-1:2];
            r_rom_row  <= w_rom_off[ROM_ADDR_BITS-1:2];
        end
        if (w_fire) begin
            r_rdata   <= w_rdata;
            r_out_tgt <= r_tgt;
            r_cs_ok   <= w_cs_ok_next;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_rdata;
    assign o_target      = r_out_tgt;
    assign o_checksum_ok = r_cs_ok;

    // ---- assertions ----
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("transaction accepted during chip RAM clear");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not reach execute");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without an executing transaction");

    a_write_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chip_req.wr || w_rom_req.wr) |-> (r_state == S_EXEC) && !w_accept)
        else $error("store write outside execute");

endmodule
